// File: src/e13_pkg.sv
// Package for the EAN-13 symbol decoder: symbol tables, types and result codes.
package e13_pkg;

    localparam int unsigned SYMBOLS_PER_CODE = 12;
    localparam int unsigned LEFT_SYMBOLS     = SYMBOLS_PER_CODE / 2;
    localparam int unsigned NUM_DIGITS       = 10;
    localparam int unsigned SYM_W            = 7;
    localparam int unsigned DIG_W            = 4;
    localparam int unsigned POS_W            = 4;
    localparam int unsigned PAR_W            = 5;

    typedef logic [SYM_W-1:0] t_sym;
    typedef logic [DIG_W-1:0] t_digit;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [PAR_W-1:0] t_par;

    localparam t_sym TAB_L [NUM_DIGITS] = '{
        7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
    };
    localparam t_sym TAB_G [NUM_DIGITS] = '{
        7'h27, 7'h33, 7'h1B, 7'h21, 7'h1D, 7'h39, 7'h05, 7'h11, 7'h09, 7'h17
    };
    localparam t_sym TAB_R [NUM_DIGITS] = '{
        7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C, 7'h4E, 7'h50, 7'h44, 7'h48, 7'h74
    };
    localparam t_par LEAD_PAT [NUM_DIGITS] = '{
        5'd31, 5'd20, 5'd18, 5'd17, 5'd12, 5'd6, 5'd3, 5'd10, 5'd9, 5'd5
    };

    typedef enum logic [1:0] {
        RC_VALID      = 2'd0,
        RC_BAD_SYMBOL = 2'd1,
        RC_BAD_PARITY = 2'd2,
        RC_CHECK      = 2'd3
    } t_result_code;

    typedef struct packed {
        t_digit digit;
        logic   found;
        logic   par;
    } t_match;

    typedef struct packed {
        t_digit       digit;
        t_pos         digit_index;
        logic         symbol_bad;
        logic         done_res;
        t_digit       first_digit;
        t_result_code result_code;
    } t_res;

endpackage

// File: src/e13_if.sv
// Valid/ready channel interfaces for symbol input beats and digit result beats.
interface ean13_in_if;
    logic                 valid;
    logic                 ready;
    logic [6:0]           symbol;
    logic                 start_req;

    modport source (output valid, output symbol, output start_req, input ready);
    modport sink   (input valid, input symbol, input start_req, output ready);
endinterface

interface ean13_out_if;
    logic                 valid;
    logic                 ready;
    logic [3:0]           digit;
    logic [3:0]           digit_index;
    logic                 symbol_bad;
    logic                 done_res;
    logic [3:0]           first_digit;
    logic [1:0]           result_code;

    modport source (output valid, output digit, output digit_index, output symbol_bad,
                    output done_res, output first_digit, output result_code, input ready);
    modport sink   (input valid, input digit, input digit_index, input symbol_bad,
                    input done_res, input first_digit, input result_code, output ready);
endinterface

// File: src/e13_sym_match.sv
// Table match of one 7-module symbol against the L/G or R code sets.
module e13_sym_match (
    input  e13_pkg::t_sym   i_symbol,
    input  logic            i_right,
    output e13_pkg::t_match o_match
);
    import e13_pkg::*;

    always_comb begin
        o_match = '0;
        for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
            if (i_right) begin
                if (TAB_R[k] == i_symbol) begin
                    o_match.digit = DIG_W'(k);
                    o_match.found = 1'b1;
                    o_match.par   = 1'b0;
                end
            end else if (TAB_L[k] == i_symbol) begin
                o_match.digit = DIG_W'(k);
                o_match.found = 1'b1;
                o_match.par   = 1'b1;
            end else if (TAB_G[k] == i_symbol) begin
                o_match.digit = DIG_W'(k);
                o_match.found = 1'b1;
                o_match.par   = 1'b0;
            end
        end
    end

endmodule

// File: src/e13_code_state.sv
// Per-code state: position, parity pattern, check sum, and the result of each symbol.
module e13_code_state (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_start_req,
    input  e13_pkg::t_match i_match,
    output logic            o_right,
    output e13_pkg::t_res   o_res
);
    import e13_pkg::*;

    t_pos        r_position, n_position;
    t_par        r_parity,   n_parity;
    t_digit      r_sum,      n_sum;
    logic        r_bad,      n_bad;

    t_pos        pos;
    t_par        par_cur;
    t_digit      sum_cur;
    logic        bad_cur;
    logic [5:0]  wsum;
    logic [4:0]  total_raw;
    t_digit      total;
    t_digit      expect_d;
    logic        pat_ok;
    t_digit      first;
    logic        last;

    always_comb begin
        if (i_start_req || (r_position >= POS_W'(SYMBOLS_PER_CODE))) begin
            pos     = '0;
            par_cur = '0;
            sum_cur = '0;
            bad_cur = 1'b0;
        end else begin
            pos     = r_position;
            par_cur = r_parity;
            sum_cur = r_sum;
            bad_cur = r_bad;
        end
    end

    assign o_right = (pos >= POS_W'(LEFT_SYMBOLS));
    assign last    = (pos == POS_W'(SYMBOLS_PER_CODE - 1));

    always_comb begin
        pat_ok = 1'b0;
        first  = '0;
        for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
            if (LEAD_PAT[k] == par_cur) begin
                pat_ok = 1'b1;
                first  = DIG_W'(k);
            end
        end
    end

    always_comb begin
        if (pos[0] == 1'b0) begin
            wsum = 6'(sum_cur) + 6'({i_match.digit, 1'b0}) + 6'(i_match.digit);
        end else begin
            wsum = 6'(sum_cur) + 6'(i_match.digit);
        end
        priority if (wsum >= 6'd30) begin
            n_sum = DIG_W'(wsum - 6'd30);
        end else if (wsum >= 6'd20) begin
            n_sum = DIG_W'(wsum - 6'd20);
        end else if (wsum >= 6'd10) begin
            n_sum = DIG_W'(wsum - 6'd10);
        end else begin
            n_sum = DIG_W'(wsum);
        end
        if (last) begin
            n_sum = '0;
        end

        total_raw = 5'(sum_cur) + 5'(first);
        total     = (total_raw >= 5'd10) ? DIG_W'(total_raw - 5'd10) : DIG_W'(total_raw);
        expect_d  = (total == '0) ? '0 : DIG_W'(5'd10 - 5'(total));
    end

    always_comb begin
        n_bad      = bad_cur | ~i_match.found;
        n_parity   = par_cur;
        n_position = pos + POS_W'(1);
        if ((pos >= POS_W'(1)) && (pos < POS_W'(LEFT_SYMBOLS))) begin
            n_parity = {par_cur[PAR_W-2:0], i_match.par & i_match.found};
        end

        o_res             = '0;
        o_res.digit       = i_match.digit;
        o_res.digit_index = pos + POS_W'(1);
        o_res.symbol_bad  = ~i_match.found;
        o_res.result_code = RC_VALID;
        if (last) begin
            o_res.done_res    = 1'b1;
            o_res.first_digit = first;
            priority if (n_bad) begin
                o_res.result_code = RC_BAD_SYMBOL;
            end else if (!pat_ok) begin
                o_res.result_code = RC_BAD_PARITY;
            end else if (i_match.digit != expect_d) begin
                o_res.result_code = RC_CHECK;
            end else begin
                o_res.result_code = RC_VALID;
            end
            n_position = '0;
            n_parity   = '0;
            n_bad      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_parity   <= '0;
            r_sum      <= '0;
            r_bad      <= 1'b0;
        end else if (i_adv) begin
            r_position <= n_position;
            r_parity   <= n_parity;
            r_sum      <= n_sum;
            r_bad      <= n_bad;
        end
    end

endmodule

// File: src/ean13_symbol_decoder.sv
// Top level of the EAN-13 symbol decoder: input register, decode, result register.
// One symbol beat per cycle in, one digit beat per cycle out while o_dig.ready is high.
// Each symbol beat is captured in an input register, matched against the L/G tables
// (symbols 1 to 6) or the R table (symbols 7 to 12), and its digit is then written to
// the result register; the sustained rate of one beat per cycle is set by the single
// pass through table match and check-sum update between the two registers. The twelfth
// beat of a code also carries done_res, the leading digit from the parity pattern and the
// status. start_req on a beat drops any partial code; after the twelfth beat the next
// beat starts a new code on its own.
module ean13_symbol_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ean13_in_if.sink    i_sym,
    ean13_out_if.source o_dig
);
    import e13_pkg::*;

    logic   r_in_valid;
    t_sym   r_symbol;
    logic   r_start;
    logic   r_out_valid;
    t_res   r_res;

    logic   adv;
    logic   right;
    t_match match;
    t_res   res;

    assign adv         = r_in_valid && (!r_out_valid || o_dig.ready);
    assign i_sym.ready = !r_in_valid || adv;

    e13_sym_match u_match (
        .i_symbol (r_symbol),
        .i_right  (right),
        .o_match  (match)
    );

    e13_code_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_start_req (r_start),
        .i_match     (match),
        .o_right     (right),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sym.ready) begin
            r_in_valid <= i_sym.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sym.ready && i_sym.valid) begin
            r_symbol <= i_sym.symbol;
            r_start  <= i_sym.start_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_dig.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_dig.valid       = r_out_valid;
    assign o_dig.digit       = r_res.digit;
    assign o_dig.digit_index = r_res.digit_index;
    assign o_dig.symbol_bad  = r_res.symbol_bad;
    assign o_dig.done_res    = r_res.done_res;
    assign o_dig.first_digit = r_res.first_digit;
    assign o_dig.result_code = r_res.result_code;

endmodule
